// ===== design/dcds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_pkg: shared types and constants for the distance cull dense set
// Field widths, action codes, register indexes, request/result/flag structs.
// ----------------------------------------------------------------------------
package dcds_pkg;

    localparam int COORD_BITS        = 24;
    localparam int ID_W              = 12;
    localparam int SLOT_W            = 12;
    localparam int CNT_W             = 13;
    localparam int ACT_W             = 3;
    localparam int ADD_W             = 23;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 23;
    localparam int MAX_TRIANGLES_DEF = 4096;
    localparam int TC_RESET_VAL      = 4096;

    localparam int ABS_W    = COORD_BITS;
    localparam int SQ_W     = 2 * COORD_BITS;
    localparam int DIST_W   = SQ_W + 2;
    localparam int ADD_SQ_W = 2 * ADD_W;
    localparam int REM_W    = ADD_W + 1;
    localparam int REM_SQ_W = 2 * REM_W;
    localparam int CMP_W    = (DIST_W > REM_SQ_W) ? DIST_W : REM_SQ_W;

    localparam logic [ADD_W-1:0] DRAW_ADD_RESET = {ADD_W{1'b1}};

    localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MOVE   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_LAST   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RANGE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TRI_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_ADD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_SLOP = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]              tri_id;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic signed [COORD_BITS-1:0] viewer_x;
        logic signed [COORD_BITS-1:0] viewer_y;
        logic signed [COORD_BITS-1:0] viewer_z;
    } in_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SLOT_W-1:0] dest_slot;
        logic [ID_W-1:0]   source_tri;
        logic [CNT_W-1:0]  active_total;
    } out_t;

    typedef struct packed {
        logic beyond_remove;
        logic within_add;
    } dist_flags_t;

endpackage

// ===== design/dcds_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_dist: squared distance and threshold compare
// Absolute differences on load, registered squares, then the sum is compared
// against the squared insert and remove distances.
// ----------------------------------------------------------------------------
module dcds_dist (
    input  logic                          clk,
    input  logic                          load,
    input  dcds_pkg::in_t                 cmd,
    input  logic [dcds_pkg::ADD_W-1:0]    draw_add,
    input  logic [dcds_pkg::ADD_W-1:0]    draw_slop,
    output dcds_pkg::dist_flags_t         flags
);
    import dcds_pkg::*;

    logic [ABS_W-1:0]    abs_x_reg;
    logic [ABS_W-1:0]    abs_y_reg;
    logic [ABS_W-1:0]    abs_z_reg;
    logic [SQ_W-1:0]     sq_x_reg;
    logic [SQ_W-1:0]     sq_y_reg;
    logic [SQ_W-1:0]     sq_z_reg;
    logic [ADD_SQ_W-1:0] add_sq_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_SQ_W-1:0] rem_sq_reg;
    logic [DIST_W-1:0]   dist2;

    function automatic logic [ABS_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        return d[COORD_BITS] ? ABS_W'(-d) : ABS_W'(d);
    endfunction

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            abs_x_reg <= abs_diff(cmd.center_x, cmd.viewer_x);
            abs_y_reg <= abs_diff(cmd.center_y, cmd.viewer_y);
            abs_z_reg <= abs_diff(cmd.center_z, cmd.viewer_z);
        end
        sq_x_reg   <= SQ_W'(abs_x_reg) * SQ_W'(abs_x_reg);
        sq_y_reg   <= SQ_W'(abs_y_reg) * SQ_W'(abs_y_reg);
        sq_z_reg   <= SQ_W'(abs_z_reg) * SQ_W'(abs_z_reg);
        // thresholds are registered from the config values; the remove square sits behind the sum register
        add_sq_reg <= ADD_SQ_W'(draw_add) * ADD_SQ_W'(draw_add);
        rem_reg    <= REM_W'(draw_add) + REM_W'(draw_slop);
        rem_sq_reg <= REM_SQ_W'(rem_reg) * REM_SQ_W'(rem_reg);
    end

    assign dist2 = DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);

    assign flags.beyond_remove = CMP_W'(dist2) > CMP_W'(rem_sq_reg);
    assign flags.within_add    = CMP_W'(dist2) < CMP_W'(add_sq_reg);

endmodule

// ===== design/dcds_maps.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcds_maps: slot-of-triangle and triangle-in-slot memories
// Two synchronous memories with registered reads and an identity clearing
// pass, started at reset and on request.
// ----------------------------------------------------------------------------
module dcds_maps #(
    parameter int MAX_TRIANGLES = dcds_pkg::MAX_TRIANGLES_DEF,
    parameter int IDX_W         = $clog2(MAX_TRIANGLES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clr_start,
    output logic             clr_busy,
    input  logic             sot_re,
    input  logic [IDX_W-1:0] sot_raddr,
    output logic [IDX_W-1:0] sot_rdata,
    input  logic             tis_re,
    input  logic [IDX_W-1:0] tis_raddr_a,
    input  logic [IDX_W-1:0] tis_raddr_b,
    output logic [IDX_W-1:0] tis_rdata_a,
    output logic [IDX_W-1:0] tis_rdata_b,
    input  logic             sot_we,
    input  logic [IDX_W-1:0] sot_waddr,
    input  logic [IDX_W-1:0] sot_wdata,
    input  logic             tis_we,
    input  logic [IDX_W-1:0] tis_waddr,
    input  logic [IDX_W-1:0] tis_wdata
);
    import dcds_pkg::*;

    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(MAX_TRIANGLES - 1);

    logic [IDX_W-1:0] sot_mem [MAX_TRIANGLES];
    logic [IDX_W-1:0] tis_mem [MAX_TRIANGLES];

    logic             clr_active_reg;
    logic             clr_active_next;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;
    logic [IDX_W-1:0] sot_rdata_reg;
    logic [IDX_W-1:0] tis_rdata_a_reg;
    logic [IDX_W-1:0] tis_rdata_b_reg;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_start)
        begin
            clr_active_next = 1'b1;
            clr_cnt_next    = '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ENTRY)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            sot_mem[clr_cnt_reg] <= clr_cnt_reg;
            tis_mem[clr_cnt_reg] <= clr_cnt_reg;
        end
        else
        begin
            if (sot_we)
            begin
                sot_mem[sot_waddr] <= sot_wdata;
            end
            if (tis_we)
            begin
                tis_mem[tis_waddr] <= tis_wdata;
            end
        end
        if (sot_re)
        begin
            sot_rdata_reg <= sot_mem[sot_raddr];
        end
        if (tis_re)
        begin
            tis_rdata_a_reg <= tis_mem[tis_raddr_a];
            tis_rdata_b_reg <= tis_mem[tis_raddr_b];
        end
    end

    assign clr_busy    = clr_active_reg;
    assign sot_rdata   = sot_rdata_reg;
    assign tis_rdata_a = tis_rdata_a_reg;
    assign tis_rdata_b = tis_rdata_b_reg;

endmodule

// ===== design/distance_cull_dense_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_cull_dense_set: distance culling of a dense triangle slot array
// Keeps slot/triangle maps in two memories, inserts near inactive triangles,
// swap-removes far active ones and issues one buffer write command each.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  request   start / busy            cmd (in_t)
//  result    done (one-cycle strobe) result (out_t)
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  a request runs in three steps: slot read at the accepting edge, dependent
//  triangle-in-slot read, then compare, map write-back and result register;
//  busy covers the last two, and done is high in the cycle after them.
//  after reset and after every triangle_count write a clearing pass over all
//  MAX_TRIANGLES entries loads identity maps; busy is high throughout.
//  cfg_ready is always high; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module distance_cull_dense_set #(
    parameter int MAX_TRIANGLES = dcds_pkg::MAX_TRIANGLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  dcds_pkg::in_t                       cmd,
    output logic                                done,
    output dcds_pkg::out_t                      result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dcds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dcds_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dcds_pkg::*;

    localparam int IDX_W = $clog2(MAX_TRIANGLES);
    localparam int CW    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam logic [CNT_W-1:0] TC_RESET =
        CNT_W'((MAX_TRIANGLES < TC_RESET_VAL) ? MAX_TRIANGLES : TC_RESET_VAL);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD1  = 2'd1;
    localparam logic [1:0] ST_RD2  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [ID_W-1:0]  id_reg;
    logic             range_reg;
    logic [CNT_W-1:0] tc_reg;
    logic             cull_en_reg;
    logic [ADD_W-1:0] draw_add_reg;
    logic [ADD_W-1:0] draw_slop_reg;
    logic [CNT_W-1:0] active_cnt_reg;
    logic [CNT_W-1:0] active_cnt_next;
    logic             done_reg;
    logic             done_next;
    out_t             result_reg;
    out_t             result_next;

    logic             accept;
    logic             cfg_wr;
    logic             tc_wr;
    logic [CNT_W-1:0] tc_sat;
    logic             clr_busy;
    dist_flags_t      flags;

    logic             sot_we;
    logic [IDX_W-1:0] sot_waddr;
    logic [IDX_W-1:0] sot_wdata;
    logic             tis_we;
    logic [IDX_W-1:0] tis_waddr;
    logic [IDX_W-1:0] tis_wdata;
    logic [IDX_W-1:0] slot_rd;
    logic [IDX_W-1:0] owner_rd;
    logic [IDX_W-1:0] moved_rd;
    logic [CNT_W-1:0] last_slot;
    logic             tri_active;
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] dest;
    logic [IDX_W-1:0] src;

    assign busy      = (state_reg != ST_IDLE) || clr_busy;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign tc_wr     = cfg_wr && (cfg_index == REG_TRI_COUNT);
    assign tc_sat    = (CW'(cfg_data[CNT_W-1:0]) > CW'(MAX_TRIANGLES))
                       ? CNT_W'(MAX_TRIANGLES) : cfg_data[CNT_W-1:0];

    dcds_dist u_dist (
        .clk       (clk),
        .load      (accept),
        .cmd       (cmd),
        .draw_add  (draw_add_reg),
        .draw_slop (draw_slop_reg),
        .flags     (flags)
    );

    dcds_maps #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .IDX_W         (IDX_W)
    ) u_maps (
        .clk         (clk),
        .rst_n       (rst_n),
        .clr_start   (tc_wr),
        .clr_busy    (clr_busy),
        .sot_re      (accept),
        .sot_raddr   (IDX_W'(cmd.tri_id)),
        .sot_rdata   (slot_rd),
        .tis_re      (state_reg == ST_RD1),
        .tis_raddr_a (slot_rd),
        .tis_raddr_b (IDX_W'(last_slot)),
        .tis_rdata_a (owner_rd),
        .tis_rdata_b (moved_rd),
        .sot_we      (sot_we),
        .sot_waddr   (sot_waddr),
        .sot_wdata   (sot_wdata),
        .tis_we      (tis_we),
        .tis_waddr   (tis_waddr),
        .tis_wdata   (tis_wdata)
    );

    assign last_slot = active_cnt_reg - 1'b1;
    // membership: the slot lies inside the dense range and points back at us
    assign tri_active = (CW'(slot_rd) < CW'(active_cnt_reg))
                        && (owner_rd == IDX_W'(id_reg));

    always_comb
    begin
        state_next      = state_reg;
        active_cnt_next = active_cnt_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        act             = ACT_NONE;
        dest            = '0;
        src             = '0;
        sot_we          = 1'b0;
        sot_waddr       = IDX_W'(id_reg);
        sot_wdata       = IDX_W'(active_cnt_reg);
        tis_we          = 1'b0;
        tis_waddr       = IDX_W'(active_cnt_reg);
        tis_wdata       = IDX_W'(id_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (range_reg)
                begin
                    act = ACT_RANGE;
                end
                else if (cull_en_reg)
                begin
                    if (tri_active)
                    begin
                        if (flags.beyond_remove)
                        begin
                            dest            = slot_rd;
                            active_cnt_next = last_slot;
                            if (CW'(slot_rd) == CW'(last_slot))
                            begin
                                act = ACT_LAST;
                            end
                            else
                            begin
                                // last slot's triangle fills the hole
                                act       = ACT_MOVE;
                                src       = moved_rd;
                                tis_we    = 1'b1;
                                tis_waddr = slot_rd;
                                tis_wdata = moved_rd;
                                sot_we    = 1'b1;
                                sot_waddr = moved_rd;
                                sot_wdata = slot_rd;
                            end
                        end
                    end
                    else if (flags.within_add
                             && (CW'(active_cnt_reg) < CW'(MAX_TRIANGLES)))
                    begin
                        act             = ACT_INSERT;
                        dest            = IDX_W'(active_cnt_reg);
                        src             = IDX_W'(id_reg);
                        sot_we          = 1'b1;
                        tis_we          = 1'b1;
                        active_cnt_next = active_cnt_reg + 1'b1;
                    end
                end
                result_next.action       = act;
                result_next.dest_slot    = SLOT_W'(dest);
                result_next.source_tri   = ID_W'(src);
                result_next.active_total = active_cnt_next;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            tc_reg         <= TC_RESET;
            cull_en_reg    <= 1'b1;
            draw_add_reg   <= DRAW_ADD_RESET;
            draw_slop_reg  <= '0;
            active_cnt_reg <= TC_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (tc_wr)
            begin
                active_cnt_reg <= tc_sat;
            end
            else
            begin
                active_cnt_reg <= active_cnt_next;
            end
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    REG_TRI_COUNT: tc_reg        <= tc_sat;
                    REG_CULL_EN:   cull_en_reg   <= cfg_data[0];
                    REG_DRAW_ADD:  draw_add_reg  <= cfg_data[ADD_W-1:0];
                    REG_DRAW_SLOP: draw_slop_reg <= cfg_data[ADD_W-1:0];
                    default:       cull_en_reg   <= cull_en_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg    <= cmd.tri_id;
            range_reg <= CW'(cmd.tri_id) >= CW'(tc_reg);
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_done_after_decide: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_RD2)
    ) else $error("result strobe without a decide cycle");

    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        active_cnt_reg <= tc_reg
    ) else $error("active count exceeds triangle count");

    a_count_quiet: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RD2) && !tc_wr |=> $stable(active_cnt_reg)
    ) else $error("active count changed outside a decide cycle");

    a_move_shrinks: assert property (
        @(posedge clk) disable iff (!rst_n)
        done && (result.action == ACT_MOVE || result.action == ACT_LAST)
            |-> active_cnt_reg == CNT_W'($past(active_cnt_reg) - 1'b1)
    ) else $error("removal did not shrink the dense array");
`endif

endmodule
